// File: rtl/core/sed_pkg.sv
// ---------------------------------------------------------------------------
// sed_pkg
// Shared types and codes for the string escape to UTF-8 decoder: the decoded
// work entry that travels from the front end to the back end, and error codes.
// ---------------------------------------------------------------------------
package sed_pkg;

    // Error codes reported on the done result.
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_OCTAL  = 3'd1;
    localparam logic [2:0] ERR_HEX_X  = 3'd2;
    localparam logic [2:0] ERR_BRACE  = 3'd3;
    localparam logic [2:0] ERR_HEX_U4 = 3'd4;

    // One thing to emit: a raw byte, or a code point to be UTF-8 encoded.
    typedef struct packed {
        logic        raw;
        logic [20:0] val;
    } t_unit;

    // Decoded work for one accepted request: up to two units, plus done info.
    typedef struct packed {
        logic [1:0] cnt;
        t_unit      u0;
        t_unit      u1;
        logic       last;
        logic [2:0] err;
    } t_entry;

endpackage

// File: rtl/core/sed_if.sv
// ---------------------------------------------------------------------------
// sed_if
// Valid/ready channels of the decoder: raw literal bytes in, UTF-8 bytes out.
// ---------------------------------------------------------------------------
interface sed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface sed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic [2:0] error_code;

    modport source (output valid, output out_byte, output byte_valid,
                    output done_res, output error_code, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input done_res, input error_code, output ready);
endinterface

// File: rtl/core/string_escape_to_utf8_decoder.sv
// ---------------------------------------------------------------------------
// string_escape_to_utf8_decoder
// Decodes the raw body of a string literal, escapes included, into UTF-8.
// ---------------------------------------------------------------------------
// The block takes one raw byte per cycle as long as its internal queue of
// QUEUE_DEPTH entries has room, and delivers one output byte per cycle while
// the receiver is ready. A request that decodes into n output bytes (one for
// ordinary text, up to six when an unpaired high surrogate is followed by
// another escape) holds the emitter until all are out; the queue absorbs such
// bursts. The first output byte of a request goes through the queue and then
// the output register. The last byte of a literal carries the done flag and
// the error code; when it yields no data a single result with byte_valid low
// carries them. After the first error no further bytes come until the end of
// the literal.
module string_escape_to_utf8_decoder
    import sed_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sed_in_if.sink    i_in_ch,
    sed_out_if.source o_out_ch
);

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;
    t_entry w_entry;
    t_entry w_head;

    // Escape parser.
    sed_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (i_in_ch),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    // Work queue.
    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // UTF-8 byte emitter.
    sed_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_out_ch (o_out_ch)
    );

    // An error code shows up only on a done result.
    a_err_only_on_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && !o_out_ch.done_res |-> o_out_ch.error_code == ERR_NONE)
        else $error("error code without done");

    // A result without data is always the done marker.
    a_marker_is_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && !o_out_ch.byte_valid |-> o_out_ch.done_res)
        else $error("empty result that is not done");

    // The emitter never retires an entry from an empty queue.
    a_no_pop_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

    // The parser never pushes into a full queue.
    a_no_push_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full && !w_pop |=> !$past(w_push))
        else $error("push into full queue");

endmodule

// File: rtl/core/sed_front.sv
// ---------------------------------------------------------------------------
// sed_front
// Escape parser. Takes one raw byte per cycle while the queue has room, tracks
// the escape state and makes each request a queue entry of at most two units.
// ---------------------------------------------------------------------------
module sed_front
    import sed_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sed_in_if.sink      i_in_ch,
    input  logic        i_full,
    output logic        o_push,
    output t_entry      o_entry
);

    // Parser modes.
    localparam logic [3:0] M_TEXT     = 4'd0;
    localparam logic [3:0] M_ESC      = 4'd1;
    localparam logic [3:0] M_ZERO     = 4'd2;
    localparam logic [3:0] M_CR       = 4'd3;
    localparam logic [3:0] M_X        = 4'd4;
    localparam logic [3:0] M_U        = 4'd5;
    localparam logic [3:0] M_U4       = 4'd6;
    localparam logic [3:0] M_BRACE    = 4'd7;
    localparam logic [3:0] M_HIGH     = 4'd8;
    localparam logic [3:0] M_HIGH_ESC = 4'd9;
    localparam logic [3:0] M_HIGH_U   = 4'd10;

    // Characters of interest.
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_B   = 8'h62;
    localparam logic [7:0] CH_F   = 8'h66;
    localparam logic [7:0] CH_V   = 8'h76;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_X   = 8'h78;
    localparam logic [7:0] CH_U   = 8'h75;
    localparam logic [7:0] CH_LBR = 8'h7B;
    localparam logic [7:0] CH_RBR = 8'h7D;

    localparam logic [7:0] BYTE_NL  = 8'h0A;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_VT  = 8'h0B;

    localparam logic [24:0] CP_MAX       = 25'h10FFFF;
    localparam logic [20:0] CP_SURR_BASE = 21'h00D800;
    localparam logic [10:0] CP_PAIR_TOP  = 11'h040;

    // Hex digit decode: bit 4 set when the byte is a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    logic [3:0]  r_mode, n_mode;
    logic [20:0] r_hv, n_hv;
    logic [2:0]  r_hc, n_hc;
    logic        r_ovf, n_ovf;
    logic [9:0]  r_high, n_high;
    logic [2:0]  r_err, n_err;

    logic [7:0]  c;
    logic        accept;
    logic [4:0]  dig;
    logic        is_dec;
    logic [15:0] nv16;
    logic [24:0] nv25;
    logic [20:0] flush_cp;
    logic [20:0] pair_cp;

    // Outcome of plain-text and escaped handling of the current byte.
    logic        p_emit;
    logic [3:0]  p_mode;
    logic        e_emit;
    logic [7:0]  e_byte;
    logic [3:0]  e_mode;
    logic        e_clr;

    t_unit       u [2];
    logic [1:0]  nu;

    assign c        = i_in_ch.in_char;
    assign accept   = i_in_ch.valid && !i_full;
    assign i_in_ch.ready = !i_full;
    assign dig      = hex_digit(c);
    assign is_dec   = (c >= CH_0) && (c <= CH_9);
    assign nv16     = {r_hv[11:0], dig[3:0]};
    assign nv25     = {r_hv, dig[3:0]};
    assign flush_cp = CP_SURR_BASE | {11'd0, r_high};
    assign pair_cp  = {({1'b0, r_high} + CP_PAIR_TOP), nv16[9:0]};

    // Plain text: a backslash opens an escape, anything else passes through.
    always_comb begin
        p_emit = (c != CH_BSL);
        p_mode = (c == CH_BSL) ? M_ESC : M_TEXT;
    end

    // Character right after a backslash.
    always_comb begin
        e_mode = M_TEXT;
        e_emit = 1'b0;
        e_byte = c;
        e_clr  = 1'b0;
        unique case (c)
            CH_N:  begin e_emit = 1'b1; e_byte = BYTE_NL;  end
            CH_T:  begin e_emit = 1'b1; e_byte = BYTE_TAB; end
            CH_R:  begin e_emit = 1'b1; e_byte = BYTE_CR;  end
            CH_B:  begin e_emit = 1'b1; e_byte = BYTE_BS;  end
            CH_F:  begin e_emit = 1'b1; e_byte = BYTE_FF;  end
            CH_V:  begin e_emit = 1'b1; e_byte = BYTE_VT;  end
            CH_0:  e_mode = M_ZERO;
            CH_LF: e_mode = M_TEXT;
            CH_CR: e_mode = M_CR;
            CH_X:  begin e_mode = M_X; e_clr = 1'b1; end
            CH_U:  e_mode = M_U;
            default: e_emit = 1'b1;
        endcase
    end

    // Next state and emitted units for the current byte, then the end of
    // the literal when this byte is the last one.
    always_comb begin
        n_mode = r_mode;
        n_hv   = r_hv;
        n_hc   = r_hc;
        n_ovf  = r_ovf;
        n_high = r_high;
        n_err  = r_err;
        u[0]   = '0;
        u[1]   = '0;
        nu     = 2'd0;

        if (r_err == ERR_NONE) begin
            unique case (r_mode)
                M_ESC: begin
                    n_mode = e_mode;
                    if (e_emit) begin
                        u[nu[0]] = '{raw: 1'b1, val: {13'd0, e_byte}};
                        nu = nu + 2'd1;
                    end
                    if (e_clr) begin
                        n_hv = '0;
                        n_hc = '0;
                    end
                end
                M_ZERO: begin
                    if (is_dec) begin
                        n_err  = ERR_OCTAL;
                        n_mode = M_TEXT;
                    end else begin
                        u[nu[0]] = '{raw: 1'b1, val: 21'd0};
                        nu = nu + 2'd1;
                        n_mode = p_mode;
                        if (p_emit) begin
                            u[nu[0]] = '{raw: 1'b1, val: {13'd0, c}};
                            nu = nu + 2'd1;
                        end
                    end
                end
                M_CR: begin
                    n_mode = M_TEXT;
                    if (c != CH_LF) begin
                        n_mode = p_mode;
                        if (p_emit) begin
                            u[nu[0]] = '{raw: 1'b1, val: {13'd0, c}};
                            nu = nu + 2'd1;
                        end
                    end
                end
                M_X: begin
                    if (!dig[4]) begin
                        n_err  = ERR_HEX_X;
                        n_mode = M_TEXT;
                    end else begin
                        n_hv = nv25[20:0];
                        n_hc = r_hc + 3'd1;
                        if (r_hc != 3'd0) begin
                            u[nu[0]] = '{raw: 1'b0, val: {13'd0, r_hv[3:0], dig[3:0]}};
                            nu = nu + 2'd1;
                            n_mode = M_TEXT;
                        end
                    end
                end
                M_U: begin
                    if (c == CH_LBR) begin
                        n_mode = M_BRACE;
                        n_hv   = '0;
                        n_hc   = '0;
                        n_ovf  = 1'b0;
                    end else if (!dig[4]) begin
                        n_err  = ERR_HEX_U4;
                        n_mode = M_TEXT;
                    end else begin
                        n_hv   = {17'd0, dig[3:0]};
                        n_hc   = 3'd1;
                        n_mode = M_U4;
                    end
                end
                M_U4: begin
                    if (!dig[4]) begin
                        n_err  = ERR_HEX_U4;
                        n_mode = M_TEXT;
                    end else begin
                        n_hv = {5'd0, nv16};
                        n_hc = r_hc + 3'd1;
                        if (r_hc >= 3'd3) begin
                            if (nv16[15:10] == 6'b110110) begin
                                n_high = nv16[9:0];
                                n_mode = M_HIGH;
                            end else begin
                                u[nu[0]] = '{raw: 1'b0, val: {5'd0, nv16}};
                                nu = nu + 2'd1;
                                n_mode = M_TEXT;
                            end
                        end
                    end
                end
                M_BRACE: begin
                    if (c == CH_RBR) begin
                        if (r_hc == 3'd0 || r_ovf) begin
                            n_err  = ERR_BRACE;
                            n_mode = M_TEXT;
                        end else begin
                            u[nu[0]] = '{raw: 1'b0, val: r_hv};
                            nu = nu + 2'd1;
                            n_mode = M_TEXT;
                        end
                    end else if (!dig[4]) begin
                        n_err  = ERR_BRACE;
                        n_mode = M_TEXT;
                    end else begin
                        n_hc = 3'd1;
                        if (!r_ovf) begin
                            if (nv25 > CP_MAX) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_hv = nv25[20:0];
                            end
                        end
                    end
                end
                M_HIGH: begin
                    if (c == CH_BSL) begin
                        n_mode = M_HIGH_ESC;
                    end else begin
                        u[nu[0]] = '{raw: 1'b0, val: flush_cp};
                        nu = nu + 2'd1;
                        n_mode = p_mode;
                        if (p_emit) begin
                            u[nu[0]] = '{raw: 1'b1, val: {13'd0, c}};
                            nu = nu + 2'd1;
                        end
                    end
                end
                M_HIGH_ESC: begin
                    if (c == CH_U) begin
                        n_mode = M_HIGH_U;
                        n_hv   = '0;
                        n_hc   = '0;
                    end else begin
                        u[nu[0]] = '{raw: 1'b0, val: flush_cp};
                        nu = nu + 2'd1;
                        n_mode = e_mode;
                        if (e_emit) begin
                            u[nu[0]] = '{raw: 1'b1, val: {13'd0, e_byte}};
                            nu = nu + 2'd1;
                        end
                        if (e_clr) begin
                            n_hv = '0;
                            n_hc = '0;
                        end
                    end
                end
                M_HIGH_U: begin
                    if (r_hc == 3'd0 && c == CH_LBR) begin
                        u[nu[0]] = '{raw: 1'b0, val: flush_cp};
                        nu = nu + 2'd1;
                        n_mode = M_BRACE;
                        n_hv   = '0;
                        n_hc   = '0;
                        n_ovf  = 1'b0;
                    end else if (!dig[4]) begin
                        u[nu[0]] = '{raw: 1'b0, val: flush_cp};
                        nu = nu + 2'd1;
                        n_err  = ERR_HEX_U4;
                        n_mode = M_TEXT;
                    end else begin
                        n_hv = {5'd0, nv16};
                        n_hc = r_hc + 3'd1;
                        if (r_hc >= 3'd3) begin
                            if (nv16[15:10] == 6'b110111) begin
                                // High and low halves merge into one code point.
                                u[nu[0]] = '{raw: 1'b0, val: pair_cp};
                                nu = nu + 2'd1;
                                n_mode = M_TEXT;
                            end else begin
                                u[nu[0]] = '{raw: 1'b0, val: flush_cp};
                                nu = nu + 2'd1;
                                if (nv16[15:10] == 6'b110110) begin
                                    n_high = nv16[9:0];
                                    n_mode = M_HIGH;
                                end else begin
                                    u[nu[0]] = '{raw: 1'b0, val: {5'd0, nv16}};
                                    nu = nu + 2'd1;
                                    n_mode = M_TEXT;
                                end
                            end
                        end
                    end
                end
                default: begin
                    // Plain text, and any unused mode code, behave the same.
                    n_mode = p_mode;
                    if (p_emit) begin
                        u[nu[0]] = '{raw: 1'b1, val: {13'd0, c}};
                        nu = nu + 2'd1;
                    end
                end
            endcase
        end

        // Close whatever escape is still open at the end of the literal.
        if (i_in_ch.in_last && n_err == ERR_NONE) begin
            unique case (n_mode)
                M_ZERO: begin
                    u[nu[0]] = '{raw: 1'b1, val: 21'd0};
                    nu = nu + 2'd1;
                end
                M_X:      n_err = ERR_HEX_X;
                M_U:      n_err = ERR_HEX_U4;
                M_U4:     n_err = ERR_HEX_U4;
                M_BRACE:  n_err = ERR_BRACE;
                M_HIGH, M_HIGH_ESC: begin
                    u[nu[0]] = '{raw: 1'b0, val: CP_SURR_BASE | {11'd0, n_high}};
                    nu = nu + 2'd1;
                end
                M_HIGH_U: begin
                    u[nu[0]] = '{raw: 1'b0, val: CP_SURR_BASE | {11'd0, n_high}};
                    nu = nu + 2'd1;
                    n_err = ERR_HEX_U4;
                end
                default: n_mode = n_mode;
            endcase
        end
    end

    // Queue entry for this request; requests that give nothing are dropped unless last.
    always_comb begin
        o_entry.cnt  = nu;
        o_entry.u0   = u[0];
        o_entry.u1   = u[1];
        o_entry.last = i_in_ch.in_last;
        o_entry.err  = n_err;
        o_push       = accept && (nu != 2'd0 || i_in_ch.in_last);
    end

    // Parser state; the end of a literal returns everything to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_TEXT;
            r_hv   <= '0;
            r_hc   <= '0;
            r_ovf  <= 1'b0;
            r_high <= '0;
            r_err  <= ERR_NONE;
        end else if (accept) begin
            if (i_in_ch.in_last) begin
                r_mode <= M_TEXT;
                r_hv   <= '0;
                r_hc   <= '0;
                r_ovf  <= 1'b0;
                r_high <= '0;
                r_err  <= ERR_NONE;
            end else begin
                r_mode <= n_mode;
                r_hv   <= n_hv;
                r_hc   <= n_hc;
                r_ovf  <= n_ovf;
                r_high <= n_high;
                r_err  <= n_err;
            end
        end
    end

endmodule

// File: rtl/core/sed_queue.sv
// ---------------------------------------------------------------------------
// sed_queue
// Small first-in first-out buffer of work entries between the parser and
// the byte emitter.
// ---------------------------------------------------------------------------
module sed_queue
    import sed_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_full,
    output logic   o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: rtl/core/sed_back.sv
// ---------------------------------------------------------------------------
// sed_back
// Byte emitter. Walks the queue head one output byte per cycle while the
// receiver is ready; encodes UTF-8 and drives the registered output channel.
// ---------------------------------------------------------------------------
module sed_back
    import sed_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_entry      i_head,
    output logic        o_pop,
    sed_out_if.source   o_out_ch
);

    // Number of output bytes for one unit.
    function automatic logic [2:0] unit_len(input t_unit u);
        logic [2:0] n;
        if (u.raw || u.val <= 21'h00007F) begin
            n = 3'd1;
        end else if (u.val <= 21'h0007FF) begin
            n = 3'd2;
        end else if (u.val <= 21'h00FFFF) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    // Byte j of a unit's encoding.
    function automatic logic [7:0] unit_byte(input t_unit u, input logic [1:0] j);
        logic [2:0] n;
        logic [7:0] b;
        n = unit_len(u);
        b = u.val[7:0];
        unique case (n)
            3'd2: b = (j == 2'd0) ? {3'b110, u.val[10:6]} : {2'b10, u.val[5:0]};
            3'd3: begin
                unique case (j)
                    2'd0:    b = {4'b1110, u.val[15:12]};
                    2'd1:    b = {2'b10, u.val[11:6]};
                    default: b = {2'b10, u.val[5:0]};
                endcase
            end
            3'd4: begin
                unique case (j)
                    2'd0: b = {5'b11110, u.val[20:18]};
                    2'd1: b = {2'b10, u.val[17:12]};
                    2'd2: b = {2'b10, u.val[11:6]};
                    default: b = {2'b10, u.val[5:0]};
                endcase
            end
            default: b = u.val[7:0];
        endcase
        return b;
    endfunction

    logic [2:0] r_pos;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_bv;
    logic       r_done;
    logic [2:0] r_err;

    logic [2:0] n0, n1;
    logic [3:0] total;
    logic       final_byte;
    logic       load;
    logic [2:0] pos_in_u1;
    logic [7:0] sel_byte;

    // Byte count of the head entry and the byte at the current position.
    always_comb begin
        n0         = (i_head.cnt != 2'd0) ? unit_len(i_head.u0) : 3'd0;
        n1         = (i_head.cnt == 2'd2) ? unit_len(i_head.u1) : 3'd0;
        total      = {1'b0, n0} + {1'b0, n1};
        pos_in_u1  = r_pos - n0;
        final_byte = (total == 4'd0) || (({1'b0, r_pos} + 4'd1) == total);
        if (r_pos < n0) begin
            sel_byte = unit_byte(i_head.u0, r_pos[1:0]);
        end else begin
            sel_byte = unit_byte(i_head.u1, pos_in_u1[1:0]);
        end
    end

    assign load  = !i_empty && (!r_valid || o_out_ch.ready);
    assign o_pop = load && final_byte;

    // Walk position inside the head entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (load) begin
            r_pos <= final_byte ? 3'd0 : r_pos + 3'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= (total == 4'd0) ? 8'd0 : sel_byte;
            r_bv   <= (total != 4'd0);
            r_done <= final_byte && i_head.last;
            r_err  <= (final_byte && i_head.last) ? i_head.err : ERR_NONE;
        end
    end

    assign o_out_ch.valid      = r_valid;
    assign o_out_ch.out_byte   = r_byte;
    assign o_out_ch.byte_valid = r_bv;
    assign o_out_ch.done_res   = r_done;
    assign o_out_ch.error_code = r_err;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for string_escape_to_utf8_decoder. Raw literal bodies,
// a few fixed ones and many random ones built from escape sequences, are fed
// in bursts. A built-in decoder predicts the UTF-8 bytes, the done flag and
// the error code of every request. Each output beat is checked in order
// against that prediction while the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sed_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int END_WAIT     = 16;
    localparam int MAX_REPORTS  = 10;

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Decoder modes of the predictor.
    typedef enum logic [3:0] {
        MODE_TEXT, MODE_ESC, MODE_ZERO, MODE_CR, MODE_X, MODE_U, MODE_U4,
        MODE_BRACE, MODE_HIGH, MODE_HIGH_ESC, MODE_HIGH_U
    } t_dec_mode;

    // Kinds of pieces a random literal is made of.
    typedef enum int {
        TOK_PLAIN, TOK_SIMPLE, TOK_ZERO, TOK_CONT, TOK_X, TOK_U4, TOK_BRACE,
        TOK_PAIR, TOK_HIGH, TOK_NOISE
    } t_tok;

    typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_SPARSE} t_ready_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_ok;
        logic       done;
        logic [2:0] err;
    } t_utf8_result;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       drain;
    } t_raw_char;

    logic i_clk;
    logic i_rst_n;

    sed_in_if  raw_ch ();
    sed_out_if utf8_ch ();

    string_escape_to_utf8_decoder DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (raw_ch),
        .o_out_ch (utf8_ch)
    );

    // Predictor state.
    t_dec_mode   pm_mode;
    logic [20:0] pm_val;
    logic [2:0]  pm_cnt;
    logic        pm_ovf;
    logic [9:0]  pm_high;
    logic        pm_have_high;
    logic [2:0]  pm_err;
    logic [7:0]  step_bytes[$];

    t_utf8_result utf8_expected_q[$];
    t_raw_char    pending_chars[$];
    logic [7:0]   lit_buf[$];

    logic        req_taken;
    int          burst_left;
    int          gap_left;
    t_ready_mode rdy_mode;
    int          ready_left;
    int          mismatches;
    int          cycles;

    // Clock.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void reset_predictor();
        pm_mode      = MODE_TEXT;
        pm_val       = '0;
        pm_cnt       = '0;
        pm_ovf       = 1'b0;
        pm_high      = '0;
        pm_have_high = 1'b0;
        pm_err       = ERR_NONE;
    endfunction

    function automatic int hex_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // Appends one predicted byte of the current request.
    function automatic void put_byte(logic [7:0] b);
        step_bytes.insert(step_bytes.size(), b);
    endfunction

    // UTF-8 encoding of one code point; surrogates are encoded like any other value.
    function automatic void put_cp(logic [20:0] cp);
        if (cp <= 21'h7F) begin
            put_byte(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end else begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
    endfunction

    // Only the first error of a literal is kept.
    function automatic void raise_error(logic [2:0] code);
        if (pm_err == ERR_NONE) pm_err = code;
        pm_mode      = MODE_TEXT;
        pm_have_high = 1'b0;
    endfunction

    function automatic void emit_high();
        put_cp(21'hD800 + {11'd0, pm_high});
        pm_have_high = 1'b0;
    endfunction

    function automatic void open_brace();
        pm_mode = MODE_BRACE;
        pm_val  = '0;
        pm_cnt  = '0;
        pm_ovf  = 1'b0;
    endfunction

    // A completed four-digit escape; a high surrogate waits for its partner.
    function automatic void end_four(logic [15:0] v);
        if (v >= 16'hD800 && v <= 16'hDBFF) begin
            pm_high      = v[9:0];
            pm_have_high = 1'b1;
            pm_mode      = MODE_HIGH;
        end else begin
            put_cp({5'd0, v});
            pm_mode = MODE_TEXT;
        end
    endfunction

    function automatic void take_plain(logic [7:0] c);
        if (c == CH_BSL) begin
            pm_mode = MODE_ESC;
        end else begin
            put_byte(c);
            pm_mode = MODE_TEXT;
        end
    endfunction

    function automatic void take_escaped(logic [7:0] c);
        pm_mode = MODE_TEXT;
        case (c)
            "n":    put_byte(8'h0A);
            "t":    put_byte(8'h09);
            "r":    put_byte(8'h0D);
            "b":    put_byte(8'h08);
            "f":    put_byte(8'h0C);
            "v":    put_byte(8'h0B);
            "0":    pm_mode = MODE_ZERO;
            CH_LF:  ;
            CH_CR:  pm_mode = MODE_CR;
            "x": begin
                pm_mode = MODE_X;
                pm_val  = '0;
                pm_cnt  = '0;
            end
            "u":    pm_mode = MODE_U;
            default: put_byte(c);
        endcase
    endfunction

    // Work out the output beats of one accepted request and queue them.
    task automatic decode_request(input logic [7:0] c, input logic last);
        int           d;
        int           n;
        logic [31:0]  nv;
        t_utf8_result r;
        step_bytes.delete();
        d = hex_of(c);
        if (pm_err == ERR_NONE) begin
            case (pm_mode)
                MODE_TEXT: take_plain(c);
                MODE_ESC:  take_escaped(c);
                MODE_ZERO: begin
                    if (c >= "0" && c <= "9") begin
                        raise_error(ERR_OCTAL);
                    end else begin
                        put_byte(8'h00);
                        take_plain(c);
                    end
                end
                MODE_CR: begin
                    // Backslash, CR and an optional LF form one continuation.
                    pm_mode = MODE_TEXT;
                    if (c != CH_LF) take_plain(c);
                end
                MODE_X: begin
                    if (d < 0) begin
                        raise_error(ERR_HEX_X);
                    end else begin
                        pm_val = {pm_val[16:0], d[3:0]};
                        pm_cnt++;
                        if (pm_cnt >= 3'd2) begin
                            put_cp({13'd0, pm_val[7:0]});
                            pm_mode = MODE_TEXT;
                        end
                    end
                end
                MODE_U: begin
                    if (c == "{") begin
                        open_brace();
                    end else if (d < 0) begin
                        raise_error(ERR_HEX_U4);
                    end else begin
                        pm_val  = 21'(d);
                        pm_cnt  = 3'd1;
                        pm_mode = MODE_U4;
                    end
                end
                MODE_U4: begin
                    if (d < 0) begin
                        raise_error(ERR_HEX_U4);
                    end else begin
                        pm_val = {5'd0, pm_val[11:0], d[3:0]};
                        pm_cnt++;
                        if (pm_cnt >= 3'd4) end_four(pm_val[15:0]);
                    end
                end
                MODE_BRACE: begin
                    if (c == "}") begin
                        if (pm_cnt == 3'd0 || pm_ovf) begin
                            raise_error(ERR_BRACE);
                        end else begin
                            put_cp(pm_val);
                            pm_mode = MODE_TEXT;
                        end
                    end else if (d < 0) begin
                        raise_error(ERR_BRACE);
                    end else begin
                        // An over-range value is remembered, never wrapped.
                        pm_cnt = 3'd1;
                        if (!pm_ovf) begin
                            nv = {7'd0, pm_val, 4'd0} | 32'(d);
                            if (nv > 32'h10FFFF) pm_ovf = 1'b1;
                            else pm_val = nv[20:0];
                        end
                    end
                end
                MODE_HIGH: begin
                    if (c == CH_BSL) begin
                        pm_mode = MODE_HIGH_ESC;
                    end else begin
                        emit_high();
                        take_plain(c);
                    end
                end
                MODE_HIGH_ESC: begin
                    if (c == "u") begin
                        pm_mode = MODE_HIGH_U;
                        pm_val  = '0;
                        pm_cnt  = '0;
                    end else begin
                        emit_high();
                        take_escaped(c);
                    end
                end
                MODE_HIGH_U: begin
                    if (pm_cnt == 3'd0 && c == "{") begin
                        emit_high();
                        open_brace();
                    end else if (d < 0) begin
                        emit_high();
                        raise_error(ERR_HEX_U4);
                    end else begin
                        pm_val = {5'd0, pm_val[11:0], d[3:0]};
                        pm_cnt++;
                        if (pm_cnt >= 3'd4) begin
                            if (pm_val[15:0] >= 16'hDC00 && pm_val[15:0] <= 16'hDFFF) begin
                                // Surrogate pair merges into one supplementary code point.
                                put_cp(21'h10000 + {1'b0, pm_high, 10'd0} +
                                       {11'd0, pm_val[9:0]});
                                pm_have_high = 1'b0;
                                pm_mode      = MODE_TEXT;
                            end else begin
                                emit_high();
                                end_four(pm_val[15:0]);
                            end
                        end
                    end
                end
                default: take_plain(c);
            endcase
        end

        // End of literal: close whatever escape is still open.
        if (last && pm_err == ERR_NONE) begin
            case (pm_mode)
                MODE_ZERO:               put_byte(8'h00);
                MODE_X:                  raise_error(ERR_HEX_X);
                MODE_U, MODE_U4:         raise_error(ERR_HEX_U4);
                MODE_BRACE:              raise_error(ERR_BRACE);
                MODE_HIGH, MODE_HIGH_ESC: emit_high();
                MODE_HIGH_U: begin
                    emit_high();
                    raise_error(ERR_HEX_U4);
                end
                default: ;
            endcase
        end

        n = step_bytes.size();
        for (int k = 0; k < n; k++) begin
            r = '{step_bytes[k], 1'b1, 1'b0, ERR_NONE};
            if (last && k == n - 1) begin
                r.done = 1'b1;
                r.err  = pm_err;
            end
            utf8_expected_q.insert(utf8_expected_q.size(), r);
        end
        if (last) begin
            if (n == 0) begin
                r = '{8'h00, 1'b0, 1'b1, pm_err};
                utf8_expected_q.insert(utf8_expected_q.size(), r);
            end
            reset_predictor();
        end
    endtask

    // ------------------------------------------------------------------------
    // Literal builder
    // ------------------------------------------------------------------------
    function automatic void lit_add(logic [7:0] b);
        lit_buf.insert(lit_buf.size(), b);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return "0" + {4'd0, v};
        return ($urandom_range(0, 1) ? "a" : "A") + {4'd0, v} - 8'd10;
    endfunction

    function automatic void add_hex(logic [23:0] v, int digits);
        for (int i = digits - 1; i >= 0; i--) lit_add(hex_char(v[i*4 +: 4]));
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) lit_add(s[i]);
    endfunction

    function automatic void add_u4(logic [15:0] v);
        lit_add(CH_BSL);
        lit_add("u");
        add_hex({8'd0, v}, 4);
    endfunction

    // Braced escape, well formed most of the time.
    function automatic void add_brace();
        int          sel;
        int          digits;
        logic [23:0] v;
        add_str("\\u{");
        sel = $urandom_range(0, 9);
        case (sel)
            0: lit_add("}");
            1: begin
                add_hex(24'($urandom_range(0, 255)), 2);
                lit_add("g");
            end
            2: begin
                add_hex(24'($urandom_range(24'h110000, 24'hFFFFFF)), 6);
                lit_add("}");
            end
            3: begin
                add_str("00");
                add_hex(24'($urandom_range(0, 24'h10FFFF)), 6);
                lit_add("}");
            end
            4: begin
                add_hex(24'h10FFFF, 6);
                lit_add("}");
            end
            default: begin
                digits = $urandom_range(1, 6);
                v = 24'($urandom_range(0, 24'h10FFFF));
                add_hex(v, digits);
                lit_add("}");
            end
        endcase
    endfunction

    function automatic void commit_literal(logic drain);
        t_raw_char item;
        for (int i = 0; i < lit_buf.size(); i++) begin
            item.ch    = lit_buf[i];
            item.last  = (i == lit_buf.size() - 1);
            item.drain = drain && (i == 0);
            pending_chars.insert(pending_chars.size(), item);
        end
        lit_buf.delete();
    endfunction

    // One random literal of a few pieces; some are cut short, maybe inside an escape.
    function automatic void queue_random_literal(logic drain);
        int         pieces;
        int         sel;
        int         cut;
        logic [7:0] b;
        string      letters;
        letters = "ntrbfv";
        pieces = $urandom_range(1, 4);
        for (int p = 0; p < pieces; p++) begin
            case (t_tok'($urandom_range(0, 9)))
                TOK_PLAIN: begin
                    for (int i = $urandom_range(1, 3); i > 0; i--) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_BSL) b = "a";
                        lit_add(b);
                    end
                end
                TOK_SIMPLE: begin
                    lit_add(CH_BSL);
                    sel = $urandom_range(0, 7);
                    if (sel < 6) lit_add(letters[sel]);
                    else lit_add(8'($urandom_range(0, 255)));
                end
                TOK_ZERO: begin
                    add_str("\\0");
                    if ($urandom_range(0, 2) == 0)
                        lit_add("0" + 8'($urandom_range(0, 9)));
                end
                TOK_CONT: begin
                    lit_add(CH_BSL);
                    sel = $urandom_range(0, 2);
                    if (sel != 1) lit_add(CH_CR);
                    if (sel != 2) lit_add(CH_LF);
                end
                TOK_X: begin
                    add_str("\\x");
                    b = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 7) == 0) begin
                        lit_add(hex_char(b[7:4]));
                        lit_add("G");
                    end else begin
                        add_hex({16'd0, b}, 2);
                    end
                end
                TOK_U4: begin
                    if ($urandom_range(0, 9) == 0) begin
                        add_str("\\u");
                        add_hex(24'($urandom_range(0, 255)), 2);
                        lit_add("/");
                    end else if ($urandom_range(0, 2) == 0) begin
                        add_u4(16'($urandom_range(16'hD800, 16'hDFFF)));
                    end else begin
                        add_u4(16'($urandom_range(0, 16'hFFFF)));
                    end
                end
                TOK_BRACE: add_brace();
                TOK_PAIR: begin
                    add_u4(16'($urandom_range(16'hD800, 16'hDBFF)));
                    add_u4(16'($urandom_range(16'hDC00, 16'hDFFF)));
                end
                TOK_HIGH: begin
                    // High surrogate followed by nothing or a random piece, seldom its partner.
                    add_u4(16'($urandom_range(16'hD800, 16'hDBFF)));
                    case ($urandom_range(0, 5))
                        0: lit_add("Q");
                        1: add_brace();
                        2: begin
                            add_str("\\u");
                            lit_add(hex_char(4'($urandom_range(0, 15))));
                            lit_add("G");
                        end
                        3: add_u4(16'($urandom_range(0, 16'hFFFF)));
                        4: add_str("\\n");
                        default: ;
                    endcase
                end
                default: begin
                    for (int i = $urandom_range(1, 3); i > 0; i--) begin
                        if ($urandom_range(0, 2) == 0) lit_add(CH_BSL);
                        else lit_add(8'($urandom_range(0, 255)));
                    end
                end
            endcase
        end
        if (lit_buf.size() > 1 && $urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, 3);
            while (cut > 0 && lit_buf.size() > 1) begin
                void'(lit_buf.pop_back());
                cut--;
            end
        end
        commit_literal(drain);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: bursts with random gaps, one request held until taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_raw_char nxt;
        logic      present;
        present = 1'b0;
        if (i_rst_n) begin
            if (raw_ch.valid && !req_taken) begin
                present = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_chars.size() != 0 &&
                         !(pending_chars[0].drain && utf8_expected_q.size() != 0)) begin
                nxt = pending_chars.pop_front();
                raw_ch.in_char <= nxt.ch;
                raw_ch.in_last <= nxt.last;
                present = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        req_taken = 1'b0;
        raw_ch.valid <= present;
    end

    // Accepted requests go straight into the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && raw_ch.valid && raw_ch.ready) begin
            decode_request(raw_ch.in_char, raw_ch.in_last);
            req_taken = 1'b1;
        end
    end

    // Receiver: switches among always ready, light stalls and heavy stalls.
    always @(negedge i_clk) begin
        logic rdy;
        if (ready_left == 0) begin
            rdy_mode   = t_ready_mode'($urandom_range(0, 2));
            ready_left = $urandom_range(10, 60);
        end else begin
            ready_left--;
        end
        case (rdy_mode)
            RDY_ALWAYS: rdy = 1'b1;
            RDY_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
            default:    rdy = ($urandom_range(0, 3) == 0);
        endcase
        utf8_ch.ready <= rdy;
    end

    // Output checker.
    always @(posedge i_clk) begin
        t_utf8_result got;
        t_utf8_result want;
        if (i_rst_n && utf8_ch.valid && utf8_ch.ready) begin
            got = '{utf8_ch.out_byte, utf8_ch.byte_valid, utf8_ch.done_res,
                    utf8_ch.error_code};
            if (utf8_expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output: byte %02h valid %0b done %0b err %0d",
                             got.data, got.byte_ok, got.done, got.err);
            end else begin
                want = utf8_expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $write("mismatch: expected byte %02h valid %0b done %0b err %0d,",
                               want.data, want.byte_ok, want.done, want.err);
                        $display(" got byte %02h valid %0b done %0b err %0d",
                                 got.data, got.byte_ok, got.done, got.err);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int directed_items;
        i_rst_n        = 1'b0;
        raw_ch.valid   = 1'b0;
        raw_ch.in_char = 8'h00;
        raw_ch.in_last = 1'b0;
        utf8_ch.ready  = 1'b0;
        req_taken      = 1'b0;
        burst_left     = 1;
        gap_left       = 0;
        rdy_mode       = RDY_ALWAYS;
        ready_left     = 0;
        mismatches     = 0;
        cycles         = 0;
        reset_predictor();

        // Byte extremes and a trailing backslash.
        lit_add(8'h00);
        lit_add(8'hFF);
        lit_add(CH_BSL);
        commit_literal(1'b0);
        // Zero escape followed by a digit.
        add_str("\\07");
        commit_literal(1'b0);
        // Surrogate pair.
        add_str("\\uD83D\\uDE00");
        commit_literal(1'b0);
        // Braced value just over the top of the code space.
        add_str("\\u{110000}");
        commit_literal(1'b0);
        directed_items = pending_chars.size();

        // Random part; the first literal waits until the directed output is in.
        queue_random_literal(1'b1);
        while (pending_chars.size() - directed_items < RANDOM_ITEMS)
            queue_random_literal($urandom_range(0, 11) == 0);

        @(negedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || raw_ch.valid) @(posedge i_clk);
        while (utf8_expected_q.size() != 0) @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);

        if (mismatches == 0 && utf8_expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sed_pkg.sv
rtl/core/sed_if.sv
rtl/core/sed_front.sv
rtl/core/sed_queue.sv
rtl/core/sed_back.sv
rtl/core/string_escape_to_utf8_decoder.sv
verif/testbench.sv
